[design/open_addressing_hash_index_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the open-addressing hash index
// Each macro expands to one labelled concurrent assertion on a clock and a
// synchronous reset.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_INDEX_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_INDEX_ASSERT_SVH

// Same-cycle implication
`define OAHI_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OAHI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/oahi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared widths, constants, codes and types of the open-addressing hash index.
// ----------------------------------------------------------------------------
package oahi_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;
  localparam int SLOT_W = 11;
  localparam int PC_W   = 11;
  localparam int STAT_W = 2;

  localparam logic [WORD_W-1:0] HASH_MUL   = 32'd7919;
  localparam logic [WORD_W-1:0] STEP_ADD   = 32'd7883;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // Remainder unit: one quotient bit per cycle
  localparam int MOD_STEPS = WORD_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_GO,
    S_HASH_WAIT,
    S_STEP_GO,
    S_STEP_WAIT,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_WORD_CHK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

[design/oahi_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_req_if
// Request channel: one find or add transaction.
// ----------------------------------------------------------------------------
interface oahi_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [oahi_pkg::WORD_W-1:0] word;
  logic [oahi_pkg::IDX_W-1:0]  index;

  modport source (output valid, action, word, index, input ready);
  modport sink   (input valid, action, word, index, output ready);
endinterface

[design/oahi_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface oahi_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [oahi_pkg::IDX_W-1:0]  found_index;
  logic [oahi_pkg::STAT_W-1:0] status;
  logic [oahi_pkg::PC_W-1:0]   probe_count;

  modport source (output valid, found_index, status, probe_count, input ready);
  modport sink   (input valid, found_index, status, probe_count, output ready);
endinterface

[design/oahi_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_cfg_if
// Configuration write channel for the table size register.
// ----------------------------------------------------------------------------
interface oahi_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [oahi_pkg::SIZE_W-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface

[design/open_addressing_hash_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_index
// Open-addressing hash table mapping a 32-bit word to a small index, with
// fixed-step probing and a word store per index.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one find (action 0) or add (action 1) transaction; rsp returns
//   exactly one result per request: found_index, status, probe_count.
//   cfg writes table_size (0 acts as 1, above SLOTS acts as SLOTS); write it
//   only while no request is outstanding. cfg.ready is always high.
// Timing:
//   One request at a time. The home slot and the probe step each go through
//   the shared bit-serial remainder unit, one after the other. Each probe
//   then reads the slot and checks it; a find that meets an occupied slot
//   also compares the stored word, and the result state hands over the result.
//   An add with an index at or above INDEX_LIMIT skips hashing and answers
//   NOT_FOUND. A walk visits at most size_eff slots (table_size clamped).
// Reset:
//   After rst the slot table is cleared one slot a cycle, all SLOTS slots, with
//   req.ready low; table_size returns to 1024. The word store is not cleared.
// Back-pressure:
//   The result waits in the rsp register while rsp.ready is low; a new
//   request is accepted meanwhile, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module open_addressing_hash_index #(
  parameter int SLOTS       = 1024,
  parameter int INDEX_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  oahi_req_if.sink    req,
  oahi_rsp_if.source  rsp,
  oahi_cfg_if.sink    cfg
);

  localparam int SAW = $clog2(SLOTS);
  localparam int IAW = $clog2(INDEX_LIMIT);

  oahi_pkg::state_t state;
  oahi_pkg::state_t state_next;

  logic [oahi_pkg::SIZE_W-1:0] table_size;
  logic [oahi_pkg::SIZE_W-1:0] size_eff;

  logic                        action_q;
  logic [oahi_pkg::WORD_W-1:0] word_q;
  logic [oahi_pkg::IDX_W-1:0]  idx_q;
  logic [oahi_pkg::WORD_W-1:0] prod;
  logic [oahi_pkg::SIZE_W-1:0] key;
  logic [oahi_pkg::SIZE_W-1:0] step;
  logic [oahi_pkg::PC_W-1:0]   pc;
  logic [oahi_pkg::SLOT_W-1:0] slot_q;
  logic [oahi_pkg::WORD_W-1:0] word_rd;
  logic [SAW-1:0]              clr_addr;

  logic [oahi_pkg::IDX_W-1:0]  res_fi;
  logic [oahi_pkg::STAT_W-1:0] res_st;
  logic [oahi_pkg::PC_W-1:0]   res_pc;
  logic [oahi_pkg::IDX_W-1:0]  res_fi_next;
  logic [oahi_pkg::STAT_W-1:0] res_st_next;
  logic [oahi_pkg::PC_W-1:0]   res_pc_next;
  logic                        res_set;

  logic                        acc_req;
  logic                        idx_bad;
  logic                        last_probe;
  logic                        advance;
  logic                        rsp_load;
  logic [oahi_pkg::SIZE_W:0]   key_sum;
  logic [oahi_pkg::SIZE_W-1:0] key_adv;

  logic                        slot_we;
  logic [SAW-1:0]              slot_wa;
  logic [oahi_pkg::SLOT_W-1:0] slot_wd;
  logic                        word_we;

  logic                        mod_start;
  logic [oahi_pkg::WORD_W-1:0] mod_dividend;
  oahi_pkg::mod_stat_t         mod_stat;
  logic [oahi_pkg::SIZE_W-1:0] mod_rem;

  logic [oahi_pkg::SLOT_W-1:0] slot_mem [SLOTS];
  logic [oahi_pkg::WORD_W-1:0] word_mem [INDEX_LIMIT];

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= oahi_pkg::SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      table_size <= cfg.table_size;
    end
  end

  // Clamp the size into 1..SLOTS
  always_comb begin
    if (table_size == '0) begin
      size_eff = oahi_pkg::SIZE_W'(1);
    end else if (int'(table_size) > SLOTS) begin
      size_eff = oahi_pkg::SIZE_W'(SLOTS);
    end else begin
      size_eff = table_size;
    end
  end

  assign req.ready  = (state == oahi_pkg::S_IDLE);
  assign acc_req    = req.valid && req.ready;
  assign idx_bad    = req.action && (int'(req.index) >= INDEX_LIMIT);
  assign last_probe = (pc == oahi_pkg::PC_W'(size_eff - oahi_pkg::SIZE_W'(1)));

  // Next probe position: key and step are both below the size
  assign key_sum = {1'b0, key} + {1'b0, step};
  assign key_adv = (key_sum >= {1'b0, size_eff}) ?
                   oahi_pkg::SIZE_W'(key_sum - {1'b0, size_eff}) :
                   key_sum[oahi_pkg::SIZE_W-1:0];

  // Shared remainder unit
  oahi_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (size_eff),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  // Sequencer: next state, strobes and result values
  always_comb begin
    state_next   = state;
    mod_start    = 1'b0;
    mod_dividend = prod;
    advance      = 1'b0;
    res_set      = 1'b0;
    res_fi_next  = '0;
    res_st_next  = oahi_pkg::STAT_OK;
    res_pc_next  = pc;
    rsp_load     = 1'b0;
    slot_we      = 1'b0;
    slot_wa      = SAW'(key);
    slot_wd      = oahi_pkg::SLOT_W'(idx_q) + oahi_pkg::SLOT_W'(1);
    word_we      = 1'b0;
    case (state)
      oahi_pkg::S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_addr;
        slot_wd = '0;
        if (clr_addr == SAW'(SLOTS - 1)) begin
          state_next = oahi_pkg::S_IDLE;
        end
      end
      oahi_pkg::S_IDLE: begin
        if (acc_req) begin
          if (idx_bad) begin
            res_set     = 1'b1;
            res_st_next = oahi_pkg::STAT_NOT_FOUND;
            res_pc_next = '0;
            state_next  = oahi_pkg::S_RESULT;
          end else begin
            state_next = oahi_pkg::S_HASH_GO;
          end
        end
      end
      oahi_pkg::S_HASH_GO: begin
        mod_start  = 1'b1;
        state_next = oahi_pkg::S_HASH_WAIT;
      end
      oahi_pkg::S_HASH_WAIT: begin
        if (mod_stat.done) begin
          state_next = oahi_pkg::S_STEP_GO;
        end
      end
      oahi_pkg::S_STEP_GO: begin
        mod_start    = 1'b1;
        mod_dividend = oahi_pkg::STEP_ADD;
        state_next   = oahi_pkg::S_STEP_WAIT;
      end
      oahi_pkg::S_STEP_WAIT: begin
        if (mod_stat.done) begin
          state_next = oahi_pkg::S_PROBE_RD;
        end
      end
      oahi_pkg::S_PROBE_RD: begin
        state_next = oahi_pkg::S_PROBE_CHK;
      end
      oahi_pkg::S_PROBE_CHK: begin
        if (slot_q == '0) begin
          // Empty slot ends the walk: add claims it, find misses
          res_set    = 1'b1;
          state_next = oahi_pkg::S_RESULT;
          if (action_q) begin
            slot_we = 1'b1;
            word_we = 1'b1;
          end else begin
            res_st_next = oahi_pkg::STAT_NOT_FOUND;
          end
        end else if (!action_q) begin
          state_next = oahi_pkg::S_WORD_CHK;
        end else begin
          advance = 1'b1;
        end
      end
      oahi_pkg::S_WORD_CHK: begin
        if (word_rd == word_q) begin
          res_set     = 1'b1;
          res_fi_next = oahi_pkg::IDX_W'(slot_q - oahi_pkg::SLOT_W'(1));
          state_next  = oahi_pkg::S_RESULT;
        end else begin
          advance = 1'b1;
        end
      end
      oahi_pkg::S_RESULT: begin
        if (!rsp.valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = oahi_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = oahi_pkg::S_IDLE;
      end
    endcase

    // Step to the next slot, or stop at the probe limit
    if (advance) begin
      if (last_probe) begin
        res_set     = 1'b1;
        res_st_next = action_q ? oahi_pkg::STAT_FULL : oahi_pkg::STAT_NOT_FOUND;
        state_next  = oahi_pkg::S_RESULT;
      end else begin
        state_next = oahi_pkg::S_PROBE_RD;
      end
    end
  end

  // State register and clear-pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= oahi_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == oahi_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + SAW'(1);
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (acc_req) begin
      action_q <= req.action;
      word_q   <= req.word;
      idx_q    <= req.index;
      prod     <= oahi_pkg::WORD_W'(req.word * oahi_pkg::HASH_MUL);
      pc       <= '0;
    end
    if (state == oahi_pkg::S_HASH_WAIT && mod_stat.done) begin
      key <= mod_rem;
    end
    if (state == oahi_pkg::S_STEP_WAIT && mod_stat.done) begin
      step <= mod_rem;
    end
    if (advance && !last_probe) begin
      key <= key_adv;
      pc  <= pc + oahi_pkg::PC_W'(1);
    end
    if (res_set) begin
      res_fi <= res_fi_next;
      res_st <= res_st_next;
      res_pc <= res_pc_next;
    end
  end

  // Slot table: one write port, registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (state == oahi_pkg::S_PROBE_RD) begin
      slot_q <= slot_mem[SAW'(key)];
    end
  end

  // Word store: written on add, read at the slot's index on find
  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[IAW'(idx_q)] <= word_q;
    end
    if (state == oahi_pkg::S_PROBE_CHK) begin
      word_rd <= word_mem[IAW'(slot_q - oahi_pkg::SLOT_W'(1))];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.found_index <= res_fi;
      rsp.status      <= res_st;
      rsp.probe_count <= res_pc;
    end
  end

  // Checks
  `include "open_addressing_hash_index_assert.svh"

  `OAHI_ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready, "request accepted while busy")
  `OAHI_ASSERT_IMPLIES(a_rsp_from_result, clk, rst, $rose(rsp.valid), $past(state) == oahi_pkg::S_RESULT, "response raised outside result state")
  `OAHI_ASSERT_IMPLIES(a_mod_idle, clk, rst, state == oahi_pkg::S_IDLE, !mod_stat.busy, "remainder unit busy while idle")

endmodule

[design/oahi_mod_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_mod_unit
// Bit-serial restoring remainder: 32-bit dividend modulo an 11-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module oahi_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [oahi_pkg::WORD_W-1:0] dividend,
  input  logic [oahi_pkg::SIZE_W-1:0] divisor,
  output oahi_pkg::mod_stat_t         stat,
  output logic [oahi_pkg::SIZE_W-1:0] rem
);

  logic                           busy;
  logic                           done;
  logic [oahi_pkg::MOD_CNT_W-1:0] cnt;
  logic [oahi_pkg::WORD_W-1:0]    dvd;
  logic [oahi_pkg::SIZE_W-1:0]    dsr;
  logic [oahi_pkg::SIZE_W-1:0]    acc;
  logic [oahi_pkg::SIZE_W:0]      trial;
  logic [oahi_pkg::SIZE_W-1:0]    acc_next;

  // Shift in the next dividend bit and subtract where the divisor fits
  always_comb begin
    trial = {acc, dvd[oahi_pkg::WORD_W-1]};
    if (trial >= {1'b0, dsr}) begin
      acc_next = oahi_pkg::SIZE_W'(trial - {1'b0, dsr});
    end else begin
      acc_next = trial[oahi_pkg::SIZE_W-1:0];
    end
  end

  // Control: count the steps and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= oahi_pkg::MOD_CNT_W'(oahi_pkg::MOD_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - oahi_pkg::MOD_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      acc <= '0;
    end else if (busy) begin
      dvd <= {dvd[oahi_pkg::WORD_W-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign rem       = acc;

endmodule
